>>> sv/kpvf_pkg.sv
// ----------------------------------------------------------------------------
// kpvf_pkg
// Shared widths, operation codes and saturating helpers for the filter.
// ----------------------------------------------------------------------------
package kpvf_pkg;

  localparam int WordBits = 48;
  localparam int FracBits = 32;
  localparam int CfgBits  = 40;
  localparam int IdxBits  = 2;
  localparam int MagBits  = WordBits - 1;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic [MagBits-1:0]         mag_t;

  localparam word_t WMAX = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WordBits-1){1'b0}}};
  localparam word_t ONE  = word_t'(1) <<< FracBits;

  // Register indexes.
  localparam logic [IdxBits-1:0] REG_QP = 2'd0;
  localparam logic [IdxBits-1:0] REG_QV = 2'd1;
  localparam logic [IdxBits-1:0] REG_RP = 2'd2;
  localparam logic [IdxBits-1:0] REG_RV = 2'd3;

  // Arithmetic unit operations.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    word_t      x;
    word_t      y;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
  } alu_rsp_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [WordBits:0] s;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) return s[WordBits] ? WMIN : WMAX;
    return s[WordBits-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [WordBits:0] s;
    s = {a[WordBits-1], a} - {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) return s[WordBits] ? WMIN : WMAX;
    return s[WordBits-1:0];
  endfunction

  // Clamp a register value to the largest word.
  function automatic word_t reg_word(logic [CfgBits-1:0] v);
    if (CfgBits >= WordBits) begin
      if ((v >> MagBits) != '0) return WMAX;
    end
    return word_t'(v);
  endfunction

endpackage

>>> sv/kpvf_alu.sv
// ----------------------------------------------------------------------------
// kpvf_alu
// Shared saturating unit: add and subtract registered straight from the request, fixed point multiply
// over four 24-bit partial products, and restoring division one bit a cycle.
// ----------------------------------------------------------------------------
module kpvf_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  kpvf_pkg::alu_req_t req,
  output kpvf_pkg::alu_rsp_t rsp
);
  import kpvf_pkg::*;

  localparam int HB    = (MagBits + 1) / 2;
  localparam int PBits = 2 * WordBits;
  localparam int QBits = MagBits + FracBits + 1;
  localparam int CntW  = $clog2(QBits + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]          st_r, st_nxt;
  logic [1:0]          op_r;
  logic                neg_r;
  logic [WordBits-1:0] a_r, b_r;
  logic [PBits-1:0]    acc_r;
  logic [1:0]          step_r;
  logic [QBits-1:0]    num_r;
  logic [QBits-1:0]    quo_r;
  logic [MagBits:0]    rem_r;
  logic [CntW-1:0]     cnt_r;
  logic                done_r;
  word_t               res_r;

  // Magnitudes keep the full word width, so the most negative word is exact.
  function automatic logic [WordBits-1:0] magn(word_t v);
    return v[WordBits-1] ? -v : v;
  endfunction

  function automatic word_t make(logic neg, logic big, mag_t m);
    if (big) return neg ? WMIN : WMAX;
    return neg ? -word_t'({1'b0, m}) : word_t'({1'b0, m});
  endfunction

  logic [HB-1:0]    pa, pb;
  logic [2*HB-1:0]  pp;
  logic [PBits-1:0] pp_sh, acc_sum, rnd;
  logic [MagBits:0] rem_sh;
  logic             ge;
  logic [QBits:0]   qr;

  always_comb begin
    pa = step_r[0] ? HB'(a_r >> HB) : HB'(a_r);
    pb = step_r[1] ? HB'(b_r >> HB) : HB'(b_r);
    pp = pa * pb;
    pp_sh = PBits'(pp) << (HB * (int'(step_r[0]) + int'(step_r[1])));
    acc_sum = acc_r + pp_sh;
    rnd = acc_r + (PBits'(1) << (FracBits - 1));
    rem_sh = {rem_r[MagBits-1:0], num_r[QBits-1]};
    ge = rem_sh >= b_r;
    qr = {1'b0, quo_r} + QBits'(1);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (req.start && (req.op == OP_MUL)) st_nxt = ST_MUL;
               else if (req.start && (req.op == OP_DIV)) st_nxt = ST_DIV;
      ST_MUL:  if (step_r == 2'd3) st_nxt = ST_FIN;
      ST_DIV:  if (cnt_r == CntW'(1)) st_nxt = ST_FIN;
      ST_FIN:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (req.start) begin
          op_r   <= req.op;
          neg_r  <= req.x[WordBits-1] ^ req.y[WordBits-1];
          a_r    <= magn(req.x);
          b_r    <= magn(req.y);
          acc_r  <= '0;
          step_r <= 2'd0;
          rem_r  <= '0;
          quo_r  <= '0;
          cnt_r  <= CntW'(QBits);
          num_r  <= QBits'(magn(req.x)) << FracBits;
          if (req.op == OP_ADD) begin
            res_r <= sat_add(req.x, req.y); done_r <= 1'b1;
          end else if (req.op == OP_SUB) begin
            res_r <= sat_sub(req.x, req.y); done_r <= 1'b1;
          end
        end
        ST_MUL: begin
          acc_r  <= acc_sum;
          step_r <= step_r + 2'd1;
        end
        ST_DIV: begin
          num_r <= num_r << 1;
          cnt_r <= cnt_r - CntW'(1);
          if (ge) begin
            rem_r <= rem_sh - b_r;
            quo_r <= {quo_r[QBits-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[QBits-2:0], 1'b0};
          end
        end
        ST_FIN: begin
          done_r <= 1'b1;
          if (op_r == OP_MUL) begin
            res_r <= make(neg_r, ((rnd >> FracBits) >> MagBits) != '0,
                          MagBits'(rnd >> FracBits));
          end else if (b_r == '0) begin
            // With a zero divisor the sign is the numerator's own.
            res_r <= (a_r == '0) ? '0 : make(neg_r, 1'b1, '0);
          end else if ({rem_r, 1'b0} >= {1'b0, b_r}) begin
            res_r <= make(neg_r, (qr >> MagBits) != '0, MagBits'(qr));
          end else begin
            res_r <= make(neg_r, (quo_r >> MagBits) != '0, MagBits'(quo_r));
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

>>> sv/kpvf_seq.sv
// ----------------------------------------------------------------------------
// kpvf_seq
// Sequencer: walks the per-axis update program through the shared unit and
// holds the estimate, covariance and temporaries in a small register file.
// ----------------------------------------------------------------------------
module kpvf_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  kpvf_pkg::word_t     obs [6],
  input  kpvf_pkg::word_t     qp,
  input  kpvf_pkg::word_t     qv,
  input  kpvf_pkg::word_t     rp,
  input  kpvf_pkg::word_t     rv,
  output logic                busy,
  output logic                fin,
  output kpvf_pkg::word_t     est [6],
  output kpvf_pkg::alu_req_t  req,
  input  kpvf_pkg::alu_rsp_t  rsp
);
  import kpvf_pkg::*;

  // Temporaries: 0 b1, 1 a1, 2 d1, 3 s11, 4 s22, 5 bb, 6 det, 7 k11, 8 k12,
  // 9 k21, 10 k22, 11 p1, 12 yp, 13 yv, 14 t0, 15 t1.
  localparam int NStep = 38;
  localparam int SW = $clog2(NStep);

  word_t         t_r [16];
  word_t         est_r [6];
  word_t         cov_r [9];
  logic          started_r;
  logic          run_r, wait_r, fin_r;
  logic [SW-1:0] pc_r;
  logic [1:0]    ax_r;

  // Step program operands: src codes 0..15 temps, 16 a, 17 b, 18 d, 19 p,
  // 20 v, 21 zp, 22 zv, 23 qp, 24 qv, 25 rp, 26 rv. dst 0..15 temp,
  // 16 a, 17 b, 18 d, 19 p, 20 v.
  typedef struct packed {
    logic [1:0] op;
    logic [4:0] sx;
    logic [4:0] sy;
    logic [4:0] dst;
  } step_t;

  function automatic step_t prog(logic [SW-1:0] i);
    case (i)
      0:  return '{OP_ADD, 17, 18, 0};
      1:  return '{OP_ADD, 16, 17, 14};
      2:  return '{OP_ADD, 14, 0, 14};
      3:  return '{OP_ADD, 14, 23, 1};
      4:  return '{OP_ADD, 18, 24, 2};
      5:  return '{OP_ADD, 1, 25, 3};
      6:  return '{OP_ADD, 2, 26, 4};
      7:  return '{OP_MUL, 0, 0, 5};
      8:  return '{OP_MUL, 3, 4, 14};
      9:  return '{OP_SUB, 14, 5, 6};
      10: return '{OP_MUL, 1, 4, 14};
      11: return '{OP_SUB, 14, 5, 14};
      12: return '{OP_DIV, 14, 6, 7};
      13: return '{OP_MUL, 0, 25, 14};
      14: return '{OP_DIV, 14, 6, 8};
      15: return '{OP_MUL, 0, 26, 14};
      16: return '{OP_DIV, 14, 6, 9};
      17: return '{OP_MUL, 2, 3, 14};
      18: return '{OP_SUB, 14, 5, 14};
      19: return '{OP_DIV, 14, 6, 10};
      20: return '{OP_ADD, 19, 20, 11};
      21: return '{OP_SUB, 21, 11, 12};
      22: return '{OP_SUB, 22, 20, 13};
      23: return '{OP_MUL, 7, 12, 14};
      24: return '{OP_MUL, 8, 13, 15};
      25: return '{OP_ADD, 14, 15, 14};
      26: return '{OP_MUL, 9, 12, 15};
      27: return '{OP_MUL, 10, 13, 12};
      28: return '{OP_ADD, 15, 12, 15};
      29: return '{OP_ADD, 20, 15, 20};
      30: return '{OP_ADD, 11, 14, 19};
      31: return '{OP_MUL, 25, 7, 16};
      32: return '{OP_MUL, 26, 8, 17};
      33: return '{OP_MUL, 26, 10, 18};
      default: return '{OP_ADD, 0, 0, 0};
    endcase
  endfunction

  localparam logic [SW-1:0] LastPc = SW'(33);

  function automatic word_t rd(logic [4:0] s, logic [1:0] ax, word_t tt [16],
                               word_t ee [6], word_t cc [9], word_t zz [6],
                               word_t q0, word_t q1, word_t r0, word_t r1);
    case (s)
      16: return cc[3*ax];
      17: return cc[3*ax+1];
      18: return cc[3*ax+2];
      19: return ee[ax];
      20: return ee[ax+3];
      21: return zz[ax];
      22: return zz[ax+3];
      23: return q0;
      24: return q1;
      25: return r0;
      26: return r1;
      default: return tt[s[3:0]];
    endcase
  endfunction

  step_t cur;
  always_comb begin
    cur       = prog(pc_r);
    req.start = run_r && !wait_r;
    req.op    = cur.op;
    req.x     = rd(cur.sx, ax_r, t_r, est_r, cov_r, obs, qp, qv, rp, rv);
    req.y     = rd(cur.sy, ax_r, t_r, est_r, cov_r, obs, qp, qv, rp, rv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      run_r     <= 1'b0;
      wait_r    <= 1'b0;
      fin_r     <= 1'b0;
      pc_r      <= '0;
      ax_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        cov_r[3*i]   <= ONE;
        cov_r[3*i+1] <= '0;
        cov_r[3*i+2] <= ONE;
      end
    end else begin
      fin_r <= 1'b0;
      if (go && !run_r) begin
        run_r <= 1'b1;
        pc_r  <= '0;
        ax_r  <= '0;
        if (!started_r) begin
          est_r     <= obs;
          started_r <= 1'b1;
        end
      end else if (run_r) begin
        if (!wait_r) wait_r <= 1'b1;
        if (rsp.done) begin
          wait_r <= 1'b0;
          case (cur.dst)
            16: cov_r[3*ax_r]   <= rsp.res;
            17: cov_r[3*ax_r+1] <= rsp.res;
            18: cov_r[3*ax_r+2] <= rsp.res;
            19: est_r[ax_r]     <= rsp.res;
            20: est_r[ax_r+3]   <= rsp.res;
            default: t_r[cur.dst[3:0]] <= rsp.res;
          endcase
          if (pc_r == LastPc) begin
            pc_r <= '0;
            if (ax_r == 2'd2) begin
              run_r <= 1'b0;
              fin_r <= 1'b1;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end else begin
            pc_r <= pc_r + SW'(1);
          end
        end
      end
    end
  end

  assign busy = run_r;
  assign fin  = fin_r;
  assign est  = est_r;

endmodule

>>> sv/kalman_position_velocity_filter.sv
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter
// Three-axis constant-velocity Kalman filter, Q16.32, saturating.
// ----------------------------------------------------------------------------
// One observation beat in gives one estimate beat out. The axes run one after
// another through a single shared arithmetic unit, 34 operations per axis,
// with a bit-serial divider. The input is not ready while an item is in work
// or its result has not been taken.
module kalman_position_velocity_filter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // obs_pos_x, obs_pos_y, obs_pos_z, obs_vel_x, obs_vel_y, obs_vel_z
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // est_pos_x, est_pos_y, est_pos_z, est_vel_x, est_vel_y, est_vel_z
  output logic [287:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [39:0]  cfg_data
);
  import kpvf_pkg::*;

  logic [CfgBits-1:0] qp_r, qv_r, rp_r, rv_r;
  word_t    obs_r [6];
  word_t    est [6];
  logic     busy, fin, go, ov_r;
  logic     go_r;
  alu_req_t req;
  alu_rsp_t rsp;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy && !ov_r && !go_r && !fin;
  assign go = go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qp_r <= CfgBits'(429497);
      qv_r <= CfgBits'(10737418);
      rp_r <= CfgBits'(171798692);
      rv_r <= CfgBits'(171798692);
      go_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_QP: qp_r <= cfg_data;
          REG_QV: qv_r <= cfg_data;
          REG_RP: rp_r <= cfg_data;
          REG_RV: rv_r <= cfg_data;
          default: ;
        endcase
      end
      go_r <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        for (int i = 0; i < 6; i++) obs_r[i] <= in_tdata[48*i +: 48];
      end
      if (fin) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) out_tdata[48*i +: 48] = est[i];
  end
  assign out_tvalid = ov_r;

  kpvf_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  kpvf_seq u_seq (
    .clk(clk), .rst_n(rst_n), .go(go), .obs(obs_r),
    .qp(reg_word(qp_r)), .qv(reg_word(qv_r)), .rp(reg_word(rp_r)), .rv(reg_word(rv_r)),
    .busy(busy), .fin(fin), .est(est), .req(req), .rsp(rsp)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("input accepted while busy");
  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_tvalid) else $error("result lost");
  a_go_starts: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy) else $error("sequencer did not start");

endmodule
